FILE: rtl/ctvs_pkg.sv
// Shared types and codes for the cosine top-k vector search block.
// Used by ctvs_score and cosine_topk_vector_search; depends on nothing.
package ctvs_pkg;

	localparam int ELEM_W  = 16;
	localparam int KEY_W   = 32;
	localparam int SCORE_W = 16;
	localparam int RANK_W  = 4;
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] MAX_RESULTS = 5'd16;

	// Operation codes of an input word
	localparam logic [1:0] OP_UPSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Status codes of a result word
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_HIT      = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;

	// Controls from the sequencer into the score unit
	typedef struct packed {
		logic clr;
		logic pair_valid;
		logic fin;
		logic zero;
	} score_ctl_t;

	// Status back from the score unit
	typedef struct packed {
		logic busy;
		logic done;
	} score_sts_t;

endpackage

FILE: rtl/ctvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ctvs_score.sv
// Sequential cosine score unit: one shared multiplier for products and the
// norm product, a bit-pair square root and a restoring divider. Uses ctvs_pkg.
module ctvs_score (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctvs_pkg::score_ctl_t       ctl,
	input  logic signed [15:0]         a,
	input  logic signed [15:0]         b,
	output ctvs_pkg::score_sts_t       sts,
	output logic signed [15:0]         score
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SQRT, S_DEN, S_DIV, S_SAT
	} state_t;

	state_t             state_q;
	logic [1:0]         phase_q;
	logic [1:0]         psel_q;
	logic               pv_q;
	logic signed [15:0] a_q, b_q;
	logic signed [51:0] prod_q;
	logic signed [39:0] dot_q;
	logic [38:0]        nl_q, nr_q;
	logic [49:0]        sqx_q, sqr_q, sqb_q;
	logic               sqsel_q;
	logic [24:0]        rl_q;
	logic [5:0]         cnt_q;
	logic [63:0]        num_q;
	logic [49:0]        rem_q;
	logic signed [15:0] score_q;
	logic               done_q;

	logic signed [25:0] m1, m2;
	logic signed [51:0] mul;
	logic [49:0]        sq_sum, sq_res;
	logic               sq_ge;
	logic [50:0]        rem2;
	logic               dge;
	logic [50:0]        rdiff;
	logic [39:0]        dabs;
	logic [63:0]        mag;
	logic signed [15:0] sat;

	// Select multiplier operands
	always_comb begin
		if (state_q == S_DEN) begin
			m1 = 26'({1'b0, rl_q});
			m2 = 26'({1'b0, sqr_q[24:0]});
		end else begin
			unique case (phase_q)
				2'd0: begin
					m1 = 26'(a_q);
					m2 = 26'(b_q);
				end
				2'd1: begin
					m1 = 26'(a_q);
					m2 = 26'(a_q);
				end
				default: begin
					m1 = 26'(b_q);
					m2 = 26'(b_q);
				end
			endcase
		end
	end

	assign mul = m1 * m2;

	// Square root step
	assign sq_sum = sqr_q + sqb_q;
	assign sq_ge  = sqx_q >= sq_sum;
	assign sq_res = sq_ge ? ((sqr_q >> 1) + sqb_q) : (sqr_q >> 1);

	// Divide step
	assign rem2  = {rem_q, num_q[63]};
	assign dge   = rem2 >= {1'b0, prod_q[49:0]};
	assign rdiff = rem2 - {1'b0, prod_q[49:0]};

	// Magnitude of the dot product, scaled
	assign dabs = dot_q[39] ? 40'(-dot_q) : 40'(dot_q);
	assign mag  = {dabs[38:0], 25'd0};

	// Saturate the signed quotient
	always_comb begin
		if (!dot_q[39]) begin
			sat = (num_q > 64'd32767) ? 16'sd32767 : $signed(num_q[15:0]);
		end else begin
			sat = (num_q > 64'd32768) ? -16'sd32768 : $signed(16'(16'd0 - num_q[15:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pv_q    <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			pv_q   <= (state_q == S_MUL);
			psel_q <= phase_q;
			if (state_q == S_MUL || state_q == S_DEN) begin
				prod_q <= mul;
			end
			// Accumulate the last product
			if (pv_q) begin
				unique case (psel_q)
					2'd0:    dot_q <= dot_q + prod_q[39:0];
					2'd1:    nl_q  <= nl_q + prod_q[38:0];
					default: nr_q  <= nr_q + prod_q[38:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (ctl.clr) begin
						dot_q <= '0;
						nl_q  <= '0;
						nr_q  <= '0;
					end else if (ctl.pair_valid) begin
						a_q     <= a;
						b_q     <= b;
						phase_q <= 2'd0;
						state_q <= S_MUL;
					end else if (ctl.fin) begin
						if (ctl.zero || nl_q == '0 || nr_q == '0) begin
							score_q <= '0;
							done_q  <= 1'b1;
						end else begin
							sqx_q   <= 50'({nl_q, 10'd0});
							sqr_q   <= '0;
							sqb_q   <= 50'(1) << 48;
							cnt_q   <= '0;
							sqsel_q <= 1'b0;
							state_q <= S_SQRT;
						end
					end
				end
				S_MUL: begin
					if (phase_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				S_SQRT: begin
					if (sq_ge) begin
						sqx_q <= sqx_q - sq_sum;
					end
					sqr_q <= sq_res;
					sqb_q <= sqb_q >> 2;
					cnt_q <= cnt_q + 6'd1;
					// Start the second root, or move on to the norm product
					if (cnt_q == 6'd24) begin
						if (!sqsel_q) begin
							rl_q    <= sq_res[24:0];
							sqx_q   <= 50'({nr_q, 10'd0});
							sqr_q   <= '0;
							sqb_q   <= 50'(1) << 48;
							cnt_q   <= '0;
							sqsel_q <= 1'b1;
						end else begin
							state_q <= S_DEN;
						end
					end
				end
				S_DEN: begin
					num_q   <= mag;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= dge ? rdiff[49:0] : rem2[49:0];
					num_q <= {num_q[62:0], dge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					score_q <= sat;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != S_IDLE) || pv_q;
	assign sts.done = done_q;
	assign score    = score_q;

endmodule

FILE: rtl/cosine_topk_vector_search.sv
// Cosine top-k vector search: store, staging buffer, score unit, ranking.
// Element words are staged while idle. Upsert end: a key search, then an element copy.
// Query end: per slot a dot product and two norms, two roots and a 64-step divide;
// ranking rescans the scores per result. Results come out one per strobe, no stall.
// Async active-low reset empties the store and sets result_limit to 16.
// Depends on ctvs_pkg, ctvs_ram and ctvs_score.
module cosine_topk_vector_search #(
	parameter int ENTRIES = 16,
	parameter int DIM     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [31:0]        entry_key,
	input  logic [31:0]        payload_tag,
	input  logic signed [15:0] element_value,
	input  logic               final_element,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_data,
	output logic               result_strobe,
	output logic [2:0]         status,
	output logic [31:0]        result_key,
	output logic [31:0]        result_tag,
	output logic signed [15:0] score,
	output logic [3:0]         rank,
	output logic               last_result
);

	localparam int SW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int LW  = $clog2(DIM + 1);
	localparam int SAW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int VW  = $clog2(ENTRIES * DIM);
	localparam int IW  = (LW > CW) ? LW : CW;

	typedef enum logic [3:0] {
		T_IDLE, T_UP_RD, T_UP_CMP, T_UP_WR, T_UP_CRD, T_UP_CWR,
		T_Q_LRD, T_Q_LCK, T_Q_ERD, T_Q_EGO, T_Q_FIN, T_Q_WAIT,
		T_R_SCAN, T_R_KRD, T_R_EMIT
	} state_t;

	state_t             state_q;
	logic [4:0]         limit_q;
	logic [CW-1:0]      cnt_q;
	logic [LW-1:0]      stg_cnt_q;
	logic [31:0]        key_q, tag_q;
	logic [IW-1:0]      i_q;
	logic [SW-1:0]      slot_q, s_q, pidx_q, best_q;
	logic               repl_q, pv_q, have_q;
	logic signed [15:0] best_sc_q;
	logic [4:0]         lim_q, j_q;
	logic [ENTRIES-1:0] used_q;

	logic               str_q, last_q;
	logic [2:0]         status_q;
	logic [31:0]        rkey_q, rtag_q;
	logic signed [15:0] score_q;
	logic [3:0]         rank_q;

	logic               accept;
	logic               stg_we;
	logic [LW-1:0]      stg_next;
	logic [15:0]        stg_rdata, vec_rdata, scr_rdata;
	logic [31:0]        key_rdata, tag_rdata;
	logic [LW-1:0]      len_rdata;
	logic               meta_we, vec_we, scr_we;
	logic [SW-1:0]      key_raddr;
	logic [4:0]         lim0;
	logic signed [15:0] unit_score;
	ctvs_pkg::score_ctl_t ctl;
	ctvs_pkg::score_sts_t sts;

	assign busy   = (state_q != T_IDLE);
	assign accept = start && !busy;

	// Stage one element per accepted upsert or query word, up to DIM elements
	assign stg_we   = accept && (op == ctvs_pkg::OP_UPSERT || op == ctvs_pkg::OP_QUERY)
		&& (stg_cnt_q < LW'(DIM));
	assign stg_next = stg_we ? LW'(stg_cnt_q + 1'b1) : stg_cnt_q;

	// Clamp the result limit to one through sixteen
	assign lim0 = (limit_q == 5'd0) ? 5'd1
		: ((limit_q > ctvs_pkg::MAX_RESULTS) ? ctvs_pkg::MAX_RESULTS : limit_q);

	assign meta_we   = (state_q == T_UP_WR);
	assign vec_we    = (state_q == T_UP_CWR);
	assign scr_we    = (state_q == T_Q_WAIT) && sts.done;
	assign key_raddr = (state_q == T_UP_RD) ? i_q[SW-1:0] : best_q;

	ctvs_ram #(.WIDTH(16), .DEPTH(DIM)) u_stg (
		.clk(clk), .we(stg_we), .waddr(stg_cnt_q[SAW-1:0]),
		.wdata(element_value), .raddr(i_q[SAW-1:0]), .rdata(stg_rdata)
	);

	ctvs_ram #(.WIDTH(16), .DEPTH(ENTRIES * DIM)) u_vec (
		.clk(clk), .we(vec_we),
		.waddr(VW'(VW'(slot_q) * VW'(DIM) + VW'(i_q))),
		.wdata(stg_rdata),
		.raddr(VW'(VW'(s_q) * VW'(DIM) + VW'(i_q))),
		.rdata(vec_rdata)
	);

	ctvs_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
		.clk(clk), .we(meta_we), .waddr(slot_q), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	ctvs_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_tag (
		.clk(clk), .we(meta_we), .waddr(slot_q), .wdata(tag_q),
		.raddr(best_q), .rdata(tag_rdata)
	);

	ctvs_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len (
		.clk(clk), .we(meta_we), .waddr(slot_q), .wdata(stg_cnt_q),
		.raddr(s_q), .rdata(len_rdata)
	);

	ctvs_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_scr (
		.clk(clk), .we(scr_we), .waddr(s_q), .wdata(unit_score),
		.raddr(i_q[SW-1:0]), .rdata(scr_rdata)
	);

	// Drive the score unit from the sequencer state
	always_comb begin
		ctl = '0;
		unique case (state_q)
			T_Q_LCK: begin
				if (len_rdata != stg_cnt_q || len_rdata == '0) begin
					ctl.fin  = 1'b1;
					ctl.zero = 1'b1;
				end else begin
					ctl.clr = 1'b1;
				end
			end
			T_Q_EGO: ctl.pair_valid = !sts.busy;
			T_Q_FIN: ctl.fin = !sts.busy;
			default: ctl = '0;
		endcase
	end

	ctvs_score u_score (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.a($signed(vec_rdata)), .b($signed(stg_rdata)),
		.sts(sts), .score(unit_score)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			limit_q   <= ctvs_pkg::MAX_RESULTS;
			cnt_q     <= '0;
			stg_cnt_q <= '0;
			str_q     <= 1'b0;
			pv_q      <= 1'b0;
		end else begin
			str_q <= 1'b0;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						stg_cnt_q <= stg_next;
						key_q     <= entry_key;
						tag_q     <= payload_tag;
						i_q       <= '0;
						if (op == ctvs_pkg::OP_CLEAR) begin
							cnt_q    <= '0;
							stg_cnt_q <= '0;
							str_q    <= 1'b1;
							status_q <= ctvs_pkg::ST_CLEARED;
							rkey_q   <= '0;
							rtag_q   <= '0;
							score_q  <= '0;
							rank_q   <= '0;
							last_q   <= 1'b1;
						end else if (op == ctvs_pkg::OP_UPSERT && final_element) begin
							if (cnt_q == '0) begin
								slot_q  <= '0;
								repl_q  <= 1'b0;
								state_q <= T_UP_WR;
							end else begin
								state_q <= T_UP_RD;
							end
						end else if (op == ctvs_pkg::OP_QUERY && final_element) begin
							if (cnt_q == '0) begin
								stg_cnt_q <= '0;
								str_q    <= 1'b1;
								status_q <= ctvs_pkg::ST_EMPTY;
								rkey_q   <= '0;
								rtag_q   <= '0;
								score_q  <= '0;
								rank_q   <= '0;
								last_q   <= 1'b1;
							end else begin
								lim_q   <= (8'(cnt_q) < 8'(lim0)) ? 5'(cnt_q) : lim0;
								s_q     <= '0;
								state_q <= T_Q_LRD;
							end
						end
					end
				end
				T_UP_RD: state_q <= T_UP_CMP;
				T_UP_CMP: begin
					if (key_rdata == key_q) begin
						slot_q  <= i_q[SW-1:0];
						repl_q  <= 1'b1;
						state_q <= T_UP_WR;
					end else if (IW'(i_q + 1'b1) == IW'(cnt_q)) begin
						if (cnt_q == CW'(ENTRIES)) begin
							// Store full: drop the staged vector
							stg_cnt_q <= '0;
							str_q    <= 1'b1;
							status_q <= ctvs_pkg::ST_FULL;
							rkey_q   <= key_q;
							rtag_q   <= tag_q;
							score_q  <= '0;
							rank_q   <= '0;
							last_q   <= 1'b1;
							state_q  <= T_IDLE;
						end else begin
							slot_q  <= cnt_q[SW-1:0];
							repl_q  <= 1'b0;
							state_q <= T_UP_WR;
						end
					end else begin
						i_q     <= IW'(i_q + 1'b1);
						state_q <= T_UP_RD;
					end
				end
				T_UP_WR: begin
					i_q     <= '0;
					state_q <= T_UP_CRD;
				end
				T_UP_CRD: state_q <= T_UP_CWR;
				T_UP_CWR: begin
					if (IW'(i_q + 1'b1) == IW'(stg_cnt_q)) begin
						if (!repl_q) begin
							cnt_q <= CW'(cnt_q + 1'b1);
						end
						stg_cnt_q <= '0;
						str_q    <= 1'b1;
						status_q <= repl_q ? ctvs_pkg::ST_REPLACED : ctvs_pkg::ST_INSERTED;
						rkey_q   <= key_q;
						rtag_q   <= tag_q;
						score_q  <= '0;
						rank_q   <= '0;
						last_q   <= 1'b1;
						state_q  <= T_IDLE;
					end else begin
						i_q     <= IW'(i_q + 1'b1);
						state_q <= T_UP_CRD;
					end
				end
				T_Q_LRD: state_q <= T_Q_LCK;
				T_Q_LCK: begin
					i_q <= '0;
					if (len_rdata != stg_cnt_q || len_rdata == '0) begin
						state_q <= T_Q_WAIT;
					end else begin
						state_q <= T_Q_ERD;
					end
				end
				T_Q_ERD: state_q <= T_Q_EGO;
				T_Q_EGO: begin
					if (!sts.busy) begin
						if (IW'(i_q + 1'b1) == IW'(stg_cnt_q)) begin
							state_q <= T_Q_FIN;
						end else begin
							i_q     <= IW'(i_q + 1'b1);
							state_q <= T_Q_ERD;
						end
					end
				end
				T_Q_FIN: begin
					if (!sts.busy) begin
						state_q <= T_Q_WAIT;
					end
				end
				T_Q_WAIT: begin
					if (sts.done) begin
						if (CW'(s_q) + CW'(1) == cnt_q) begin
							j_q     <= '0;
							i_q     <= '0;
							have_q  <= 1'b0;
							pv_q    <= 1'b0;
							used_q  <= '0;
							state_q <= T_R_SCAN;
						end else begin
							s_q     <= SW'(s_q + 1'b1);
							state_q <= T_Q_LRD;
						end
					end
				end
				T_R_SCAN: begin
					// Walk the scores, keep the best unused one
					pv_q   <= (i_q < IW'(cnt_q));
					pidx_q <= i_q[SW-1:0];
					if (i_q < IW'(cnt_q)) begin
						i_q <= IW'(i_q + 1'b1);
					end
					if (pv_q && !used_q[pidx_q]
						&& (!have_q || $signed(scr_rdata) > best_sc_q)) begin
						best_q    <= pidx_q;
						best_sc_q <= $signed(scr_rdata);
						have_q    <= 1'b1;
					end
					if (!pv_q && i_q == IW'(cnt_q)) begin
						state_q <= T_R_KRD;
					end
				end
				T_R_KRD: state_q <= T_R_EMIT;
				T_R_EMIT: begin
					used_q[best_q] <= 1'b1;
					str_q    <= 1'b1;
					status_q <= ctvs_pkg::ST_HIT;
					rkey_q   <= key_rdata;
					rtag_q   <= tag_rdata;
					score_q  <= best_sc_q;
					rank_q   <= j_q[3:0];
					last_q   <= (5'(j_q + 5'd1) == lim_q);
					if (5'(j_q + 5'd1) == lim_q) begin
						stg_cnt_q <= '0;
						state_q  <= T_IDLE;
					end else begin
						j_q     <= 5'(j_q + 5'd1);
						i_q     <= '0;
						have_q  <= 1'b0;
						pv_q    <= 1'b0;
						state_q <= T_R_SCAN;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign result_strobe = str_q;
	assign status        = status_q;
	assign result_key    = rkey_q;
	assign result_tag    = rtag_q;
	assign score         = score_q;
	assign rank          = rank_q;
	assign last_result   = last_q;

	// The final result of a word leaves the block ready again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_result |-> !busy)
		else $error("busy after final result");

	// Non-final results only come out of a ranking pass
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_result |-> busy && status == ctvs_pkg::ST_HIT)
		else $error("non-final result outside ranking");

	// The store never holds more entries than it has slots
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ENTRIES))
		else $error("entry count overflow");

endmodule
